// File: sv/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TWICE_W  = 17;
   localparam int KEY_W    = 22;
   localparam int EC_W     = 7;
   localparam int EC_MAX   = 127;

   // Tie-break key of a below-all stump, past every midpoint key
   localparam logic signed [KEY_W-1:0] BELOW_KEY = KEY_W'(1048576);

   // Data that shifts along the row of cells
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       label;
      logic signed [TWICE_W-1:0]  pair;
   } cell_data_type;

   // Shift enables for the two chains of stored words
   typedef struct packed {
      logic samp_shift;
      logic pair_shift;
   } shift_ctrl_type;

   // Candidate stump travelling through the cells
   typedef struct packed {
      logic                      valid;
      logic                      fin;
      logic                      below;
      logic                      dir;
      logic signed [TWICE_W-1:0] twice;
   } cand_type;

   // Stored best stump
   typedef struct packed {
      logic                      below;
      logic                      dir;
      logic signed [TWICE_W-1:0] twice;
   } best_type;

   // s * threshold, in units of 2^-17 for midpoints
   function automatic logic signed [KEY_W-1:0] tie_key(
      input logic below, input logic dir, input logic signed [TWICE_W-1:0] twice);
      logic signed [KEY_W-1:0] ext;
      ext = KEY_W'(twice);
      if (below) begin
         tie_key = dir ? -BELOW_KEY : BELOW_KEY;
      end else begin
         tie_key = dir ? ext : -ext;
      end
   endfunction

endpackage

// File: sv/dss_cell.sv
`timescale 1ns / 1ps

module dss_cell import dss_pkg::*; #(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  shift_ctrl_type ctrl,
   input  logic [CW-1:0]  base,
   input  cell_data_type  data_i,
   output cell_data_type  data_o,
   input  cand_type       cand_i,
   input  logic [CW-1:0]  errs_i,
   output cand_type       cand_o,
   output logic [CW-1:0]  errs_o
);

   cell_data_type data_ff, data_in;
   cand_type      cand_ff;
   logic [CW-1:0] errs_ff;

   logic signed [TWICE_W:0] diff;
   logic                    occupied;
   logic                    pos;
   logic                    miss;

   always_comb begin
      data_in = data_ff;
      if (ctrl.samp_shift) begin
         data_in.sample = data_i.sample;
         data_in.label  = data_i.label;
      end
      if (ctrl.pair_shift) begin
         data_in.pair = data_i.pair;
      end
   end

   // Prediction of the passing stump on the stored sample
   assign diff = {data_ff.sample[SAMPLE_W-1], data_ff.sample, 1'b0}
               - {cand_i.twice[TWICE_W-1], cand_i.twice};
   assign occupied = (base <= CW'(IDX));

   always_comb begin
      if (cand_i.below) begin
         pos = cand_i.dir;
      end else if (cand_i.dir) begin
         pos = !diff[TWICE_W] && (diff != '0);
      end else begin
         pos = diff[TWICE_W];
      end
   end

   assign miss = occupied && cand_i.valid && (pos != data_ff.label);

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      errs_ff <= errs_i + CW'(miss);
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_i;
      end
   end

   assign data_o = data_ff;
   assign cand_o = cand_ff;
   assign errs_o = errs_ff;

endmodule

// File: sv/dss_best.sv
`timescale 1ns / 1ps

module dss_best import dss_pkg::*; #(
   parameter int CW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  cand_type      cand,
   input  logic [CW-1:0] errs,
   output best_type      best,
   output logic [CW-1:0] best_errs,
   output logic          done
);

   best_type      best_ff, best_in;
   logic [CW-1:0] errs_ff, errs_in;
   logic          have_ff, have_in;
   logic          done_ff;
   logic          take;

   assign take = cand.valid &&
                 (!have_ff || (errs < errs_ff) ||
                  ((errs == errs_ff) &&
                   (tie_key(cand.below, cand.dir, cand.twice) <
                    tie_key(best_ff.below, best_ff.dir, best_ff.twice))));

   always_comb begin
      best_in = best_ff;
      errs_in = errs_ff;
      have_in = have_ff;
      if (take) begin
         best_in.below = cand.below;
         best_in.dir   = cand.dir;
         best_in.twice = cand.below ? '0 : cand.twice;
         errs_in       = errs;
         have_in       = 1'b1;
      end
      if (clear) begin
         have_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      errs_ff <= errs_in;
      if (reset) begin
         have_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
         done_ff <= cand.valid && cand.fin;
      end
   end

   assign best      = best_ff;
   assign best_errs = errs_ff;
   assign done      = done_ff;

endmodule

// File: sv/decision_stump_search_top.sv
`timescale 1ns / 1ps

// Decision stump trainer over one-dimensional samples. Words on the req side carry a
// signed 16-bit sample (units of 2^-16, ascending) with its label in tuser; tlast closes
// a set, and that word alone produces one rsp word with the best stump found. Each
// sample is taken in one cycle while loading. Up to MAX_POINTS samples are kept in a
// row of identical cells, one sample per cell; further samples are dropped and flagged
// in the result. After the closing word the row shifts so the stored set sits at the far
// end, then 2n candidate stumps enter the row one per cycle and each collects its error
// count as it moves one cell per cycle. No req word is taken during training; loading of
// the next set may start while the previous result still waits on rsp.
module decision_stump_search_top import dss_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] label
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [16:0] threshold_twice, [17] below_all,
                                    // [18] best_sign, [25:19] error_count,
                                    // [26] overflowed, [31:27] zero
);

   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_ALIGN = 5'b00010,
      ST_TRAIN = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;      // samples stored in this set
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] base_ff, base_in;        // first occupied cell after alignment
   logic [CW-1:0] align_ff, align_in;
   logic [CW-1:0] mid_ff, mid_in;          // midpoints still to inject
   logic          dir_ff, dir_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          store;
   logic [CW-1:0] count_next;
   logic          clear_best;

   shift_ctrl_type ctrl;
   cand_type       head;
   cell_data_type  feed;
   cell_data_type  data_q [MAX_POINTS];
   cand_type       cand_q [MAX_POINTS];
   logic [CW-1:0]  errs_q [MAX_POINTS];

   best_type      best;
   logic [CW-1:0] best_errs;
   logic          best_done;
   logic [CW+7:0] errs_wide;
   logic [EC_W-1:0] err_sat;

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign store      = accept && (count_ff < CW'(MAX_POINTS));
   assign count_next = store ? count_ff + CW'(1) : count_ff;

   // New word enters cell 0 with the sum of itself and its predecessor
   assign feed.sample = req_tdata;
   assign feed.label  = req_tuser;
   assign feed.pair   = TWICE_W'(prev_ff) + TWICE_W'(signed'(req_tdata));

   // Saturate the error count to the result field
   assign errs_wide = (CW+8)'(best_errs);
   assign err_sat   = (errs_wide > (CW+8)'(EC_MAX)) ? EC_W'(EC_MAX) : errs_wide[EC_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      base_in      = base_ff;
      align_in     = align_ff;
      mid_in       = mid_ff;
      dir_in       = dir_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;
      head         = '0;
      clear_best   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = count_next;
               if (store) begin
                  ctrl.samp_shift = 1'b1;
                  ctrl.pair_shift = 1'b1;
                  prev_in         = req_tdata;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  // Push the set to the far end, plus one pair shift to skip the
                  // oldest cell, which has no left neighbor
                  base_in  = CW'(MAX_POINTS) - count_next;
                  align_in = CW'(MAX_POINTS) - count_next + CW'(1);
                  mid_in   = count_next - CW'(1);
                  dir_in   = 1'b0;
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            ctrl.pair_shift = 1'b1;
            ctrl.samp_shift = (align_ff != CW'(1));
            align_in        = align_ff - CW'(1);
            if (align_ff == CW'(1)) begin
               state_in = ST_TRAIN;
            end
         end
         ST_TRAIN: begin
            head.valid = 1'b1;
            head.dir   = dir_ff;
            dir_in     = !dir_ff;
            if (mid_ff != '0) begin
               head.twice = data_q[MAX_POINTS-1].pair;
               if (dir_ff) begin
                  ctrl.pair_shift = 1'b1;
                  mid_in          = mid_ff - CW'(1);
               end
            end else begin
               head.below = 1'b1;
               head.fin   = dir_ff;
               if (dir_ff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (best_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Wait for the output register to free up, then reopen for the next set
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, ovf_ff, err_sat, best.dir, best.below, best.twice};
               clear_best   = 1'b1;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      align_ff    <= align_in;
      mid_ff      <= mid_in;
      dir_ff      <= dir_in;
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Row of cells: stored words shift up, candidates travel up collecting errors
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      cell_data_type din;
      cand_type      cin;
      logic [CW-1:0] ein;
      if (k == 0) begin : g_head
         assign din = feed;
         assign cin = head;
         assign ein = '0;
      end else begin : g_link
         assign din = data_q[k-1];
         assign cin = cand_q[k-1];
         assign ein = errs_q[k-1];
      end
      dss_cell #(
         .CW  (CW),
         .IDX (k)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .base   (base_ff),
         .data_i (din),
         .data_o (data_q[k]),
         .cand_i (cin),
         .errs_i (ein),
         .cand_o (cand_q[k]),
         .errs_o (errs_q[k])
      );
   end

   dss_best #(
      .CW (CW)
   ) u_best (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear_best),
      .cand      (cand_q[MAX_POINTS-1]),
      .errs      (errs_q[MAX_POINTS-1]),
      .best      (best),
      .best_errs (best_errs),
      .done      (best_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Stored count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("sample count above capacity");

   // The closing candidate only leaves the row while the controller drains
   a_fin_drain: assert property (@(posedge clock) disable iff (reset)
      (cand_q[MAX_POINTS-1].valid && cand_q[MAX_POINTS-1].fin) |-> (state_ff == ST_DRAIN))
      else $error("final candidate outside drain");

   // Training never starts on an empty set
   a_train_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRAIN) |-> (count_ff != '0))
      else $error("training with no samples");

   // A result is loaded only when the output register is free or being drained
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && state_ff == ST_EMIT) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule
